@@ hw/rtl/cdq_pkg.sv @@
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 40;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic exec;
        logic load_out;
    } t_cdq_cmd;

    typedef struct packed {
        logic pending;
        logic out_valid;
    } t_cdq_stat;

endpackage

@@ hw/rtl/cdq_ctrl.sv @@
module cdq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output cdq_pkg::t_cdq_cmd  o_cmd,
    output cdq_pkg::t_cdq_stat o_stat
);
    import cdq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_PEND = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic accept;
    logic load_out;

    assign out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) || out_free;
    assign accept = i_s_tvalid && o_s_tready;
    assign load_out = (r_state == S_PEND) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_PEND;
            end
            S_PEND: begin
                if (accept) n_state = S_PEND;
                else if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_cmd.exec       = accept;
    assign o_cmd.load_out   = load_out;
    assign o_stat.pending   = (r_state == S_PEND);
    assign o_stat.out_valid = r_out_valid;

endmodule

@@ hw/rtl/cdq_dpath.sv @@
module cdq_dpath #(
    parameter int DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdq_pkg::t_cdq_cmd           i_cmd,
    input  logic [cdq_pkg::ACT_W-1:0]   i_action,
    input  logic [cdq_pkg::DATA_W-1:0]  i_data_in,
    output logic [cdq_pkg::OUT_W-1:0]   o_result
);
    import cdq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [PW-1:0] r_front, n_front;
    logic [PW-1:0] r_rear, n_rear;
    logic          r_empty, n_empty;

    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic              r_res_pop, n_res_pop;
    logic              r_res_empty;
    logic              r_res_full;
    logic [DATA_W-1:0] r_rd_data;

    logic [DATA_W-1:0] r_out_data;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_empty;
    logic              r_out_full;

    logic [PW-1:0] front_next, front_prev, rear_next, rear_prev, n_rear_next;
    logic          is_push, is_full, n_full;
    logic          wr_en, rd_en;
    logic [PW-1:0] wr_addr, rd_addr;

    assign front_next  = (r_front == LAST) ? '0 : r_front + 1'b1;
    assign front_prev  = (r_front == '0) ? LAST : r_front - 1'b1;
    assign rear_next   = (r_rear == LAST) ? '0 : r_rear + 1'b1;
    assign rear_prev   = (r_rear == '0) ? LAST : r_rear - 1'b1;
    assign n_rear_next = (n_rear == LAST) ? '0 : n_rear + 1'b1;

    assign is_push = (i_action == ACT_PUSH_FRONT) || (i_action == ACT_PUSH_REAR);
    assign is_full = !r_empty && (rear_next == r_front);
    assign n_full  = !n_empty && (n_rear_next == n_front);

    always_comb begin
        n_front      = r_front;
        n_rear       = r_rear;
        n_empty      = r_empty;
        n_res_status = ST_DONE;
        n_res_pop    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = r_front;
        if (is_push) begin
            if (r_empty) begin
                n_front = '0;
                n_rear  = '0;
                n_empty = 1'b0;
                wr_en   = 1'b1;
                wr_addr = '0;
            end else if (is_full) begin
                n_res_status = ST_OVERFLOW;
            end else if (i_action == ACT_PUSH_FRONT) begin
                n_front = front_prev;
                wr_en   = 1'b1;
                wr_addr = front_prev;
            end else begin
                n_rear  = rear_next;
                wr_en   = 1'b1;
                wr_addr = rear_next;
            end
        end else begin
            if (r_empty) begin
                n_res_status = ST_UNDERFLOW;
            end else if (r_front == r_rear) begin
                rd_en     = 1'b1;
                n_res_pop = 1'b1;
                n_front   = '0;
                n_rear    = '0;
                n_empty   = 1'b1;
            end else if (i_action == ACT_POP_FRONT) begin
                rd_en     = 1'b1;
                n_res_pop = 1'b1;
                n_front   = front_next;
            end else begin
                rd_en     = 1'b1;
                n_res_pop = 1'b1;
                rd_addr   = r_rear;
                n_rear    = rear_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) mem[wr_addr] <= i_data_in;
        if (i_cmd.exec && rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
            r_res_pop    <= n_res_pop;
            r_res_empty  <= n_empty;
            r_res_full   <= n_full;
        end
        if (i_cmd.load_out) begin
            r_out_data   <= r_res_pop ? r_rd_data : '0;
            r_out_status <= r_res_status;
            r_out_empty  <= r_res_empty;
            r_out_full   <= r_res_full;
        end
    end

    assign o_result = {4'b0, r_out_full, r_out_empty, r_out_status, r_out_data};

`ifndef ASSERT_OFF
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0) && (r_rear == '0))
        else $error("empty deque with nonzero pointers");

    a_ovf_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && is_push && is_full |=>
            $stable(r_front) && $stable(r_rear) && (r_res_status == ST_OVERFLOW))
        else $error("refused push changed pointers");

    a_unf_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !is_push && r_empty |=>
            (r_res_status == ST_UNDERFLOW) && !r_res_pop && r_empty)
        else $error("refused pop returned data or changed state");
`endif

endmodule

@@ hw/rtl/circular_deque.sv @@
// Channel  Dir  Handshake                       Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready tuser: action; tdata: data_in
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready tdata: data_out, status, is_empty, is_full
//
// One word per cycle sustained while m_axis takes results; a result goes through the result and output registers.
// Pops read the slot ring through one registered read port; pushes write it at the same edge.
// One finished result waits in the output register while the next one is pending.
// Reset: empty deque, both pointers at slot 0; slot contents are not cleared.
// A stalled m_axis holds the input side after one further word is taken.
module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [cdq_pkg::DATA_W-1:0]   i_s_axis_tdata,  // [31:0] data_in
    input  logic [cdq_pkg::ACT_W-1:0]    i_s_axis_tuser,  // [1:0] action
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [31:0] data_out, [33:32] status, [34] is_empty, [35] is_full
    output logic [cdq_pkg::OUT_W-1:0]    o_m_axis_tdata
);
    import cdq_pkg::*;

    t_cdq_cmd  cmd;
    t_cdq_stat stat;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (cmd),
        .o_stat     (stat)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_action  (i_s_axis_tuser),
        .i_data_in (i_s_axis_tdata),
        .o_result  (o_m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_load_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.pending && (!stat.out_valid || i_m_axis_tready))
        else $error("result loaded with none pending or output busy");
`endif

endmodule
